@@ rtl/tgb_pkg.sv @@
// ----------------------------------------------------------------------------
// tgb_pkg
// Shared types and constants for the text to glyph blit rectangle mapper.
// ----------------------------------------------------------------------------
package tgb_pkg;

  // Input beat: one command, or one text byte of a string.
  typedef struct packed {
    logic               cmd;
    logic [7:0]         text_byte;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [31:0]        default_color;
    logic [11:0]        rect_capacity;
  } in_item_t;

  // Output beat: one blit rectangle, or the terminator record.
  typedef struct packed {
    logic               available;
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic [9:0]         src_x1;
    logic [8:0]         src_y1;
    logic [9:0]         src_x2;
    logic [8:0]         src_y2;
    logic [31:0]        draw_color;
    logic [5:0]         palette_index;
  } out_item_t;

  // Command codes
  localparam logic CmdBegin = 1'b0;
  localparam logic CmdByte  = 1'b1;

  // What the back end has to build
  typedef enum logic [1:0] {
    JobTerm,
    JobAscii,
    JobHangul,
    JobBlank
  } job_kind_e;

  // Classified glyph handed from the front end to the back end.
  // glyph holds the ASCII cell number or the Hangul glyph number.
  typedef struct packed {
    job_kind_e          kind;
    logic [11:0]        glyph;
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic [31:0]        color;
    logic [5:0]         pal;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Byte codes
  localparam logic [7:0] ByteNul      = 8'h00;
  localparam logic [7:0] ByteAt       = 8'h40;
  localparam logic [7:0] ByteSpace    = 8'h20;
  localparam logic [7:0] ByteDigit0   = 8'h30;
  localparam logic [7:0] ByteDigit9   = 8'h39;
  localparam logic [7:0] ByteUpperA   = 8'h41;
  localparam logic [7:0] ByteUpperZ   = 8'h5A;
  localparam logic [7:0] ByteLowerA   = 8'h61;
  localparam logic [7:0] ByteLowerZ   = 8'h7A;

  // KS X 1001 ranges
  localparam logic [7:0] JamoLead     = 8'hA4;
  localparam logic [7:0] JamoTrailLo  = 8'hA1;
  localparam logic [7:0] JamoTrailHi  = 8'hD3;
  localparam logic [7:0] SyllLeadLo   = 8'hB0;
  localparam logic [7:0] SyllLeadHi   = 8'hC8;
  localparam logic [7:0] TrailLo      = 8'hA1;
  localparam logic [7:0] TrailHi      = 8'hFE;
  localparam logic [11:0] SyllPerRow  = 12'd94;
  localparam logic [11:0] JamoCount   = 12'd51;

  localparam logic [5:0] NoIndex      = 6'd36;

  // Atlas geometry
  localparam logic [9:0]  AsciiW      = 10'd6;
  localparam logic [9:0]  AsciiLeft   = 10'd6;
  localparam logic [8:0]  AsciiTop    = 9'd20;
  localparam logic [8:0]  AsciiH      = 9'd12;
  localparam logic [9:0]  HanW        = 10'd12;
  localparam logic [8:0]  HanH        = 9'd12;
  localparam logic [8:0]  HanTop      = 9'd32;
  localparam logic [11:0] HanPitch    = 12'd85;
  localparam logic [15:0] AsciiAdv    = 16'd6;
  localparam logic [15:0] HanAdv      = 16'd12;

  // g / 85 as (g * HanRecip) >> HanShift, exact for g below 15000
  localparam logic [13:0] HanRecip    = 14'd12337;
  localparam int          HanShift    = 20;

endpackage

@@ rtl/tgb_in_if.sv @@
// ----------------------------------------------------------------------------
// tgb_in_if
// Valid/ready channel that carries input beats.
// ----------------------------------------------------------------------------
interface tgb_in_if;
  logic              valid;
  logic              ready;
  tgb_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/tgb_out_if.sv @@
// ----------------------------------------------------------------------------
// tgb_out_if
// Valid/ready channel that carries blit rectangle beats.
// ----------------------------------------------------------------------------
interface tgb_out_if;
  logic               valid;
  logic               ready;
  tgb_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/tgb_front.sv @@
// ----------------------------------------------------------------------------
// tgb_front
// Accepts string bytes, tracks escape, lead byte, cursor and slots, and
// pushes one classified job per rectangle or terminator.
// ----------------------------------------------------------------------------
module tgb_front #(
  parameter int MAX_RECTS = 4095
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tgb_in_if.sink              in_i,
  input  tgb_pkg::q_status_t  status_i,
  output logic                push_o,
  output tgb_pkg::job_t       job_o
);

  localparam int SlotW = $clog2(MAX_RECTS + 1);

  logic               active_q, active_d;
  logic               esc_q, esc_d;
  logic               lead_v_q, lead_v_d;
  logic [7:0]         lead_q, lead_d;
  logic [15:0]        cur_x_q, cur_x_d;
  logic [15:0]        cur_y_q, cur_y_d;
  logic [31:0]        color_q, color_d;
  logic [SlotW-1:0]   slots_q, slots_d;
  logic [5:0]         pal_q, pal_d;

  logic               acc;
  logic [7:0]         b;
  tgb_pkg::in_item_t  it;

  assign in_i.ready = !status_i.full;
  assign acc        = in_i.valid && in_i.ready;
  assign it         = in_i.payload;
  assign b          = it.text_byte;

  always_comb begin
    active_d = active_q;
    esc_d    = esc_q;
    lead_v_d = lead_v_q;
    lead_d   = lead_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    color_d  = color_q;
    slots_d  = slots_q;
    pal_d    = pal_q;
    push_o   = 1'b0;
    job_o    = '0;
    job_o.kind = tgb_pkg::JobTerm;

    if (acc) begin
      if (it.cmd == tgb_pkg::CmdBegin) begin
        active_d = 1'b1;
        esc_d    = 1'b0;
        lead_v_d = 1'b0;
        lead_d   = '0;
        cur_x_d  = it.start_x;
        cur_y_d  = it.start_y;
        color_d  = it.default_color;
        if (32'(it.rect_capacity) > 32'(MAX_RECTS)) begin
          slots_d = SlotW'(MAX_RECTS);
        end else begin
          slots_d = SlotW'(32'(it.rect_capacity));
        end
      end else if (active_q) begin
        if (b == tgb_pkg::ByteNul) begin
          // terminator: drop any pending lead byte or escape
          push_o   = 1'b1;
          esc_d    = 1'b0;
          lead_v_d = 1'b0;
          active_d = 1'b0;
        end else if (esc_q) begin
          esc_d = 1'b0;
          if (b == tgb_pkg::ByteAt) begin
            pal_d = tgb_pkg::NoIndex;
          end else if (b >= tgb_pkg::ByteDigit0 && b <= tgb_pkg::ByteDigit9) begin
            pal_d = 6'(b - tgb_pkg::ByteDigit0);
          end else if (b >= tgb_pkg::ByteUpperA && b <= tgb_pkg::ByteUpperZ) begin
            pal_d = 6'(b - tgb_pkg::ByteUpperA + 8'd10);
          end else if (b >= tgb_pkg::ByteLowerA && b <= tgb_pkg::ByteLowerZ) begin
            pal_d = 6'(b - tgb_pkg::ByteLowerA + 8'd10);
          end
        end else if (!lead_v_q && b == tgb_pkg::ByteAt) begin
          esc_d = 1'b1;
        end else if (!lead_v_q && b[7]) begin
          lead_v_d = 1'b1;
          lead_d   = b;
        end else begin
          lead_v_d = 1'b0;
          if (slots_q == '0) begin
            // out of slots: close the string silently
            active_d = 1'b0;
          end else begin
            slots_d      = slots_q - SlotW'(1);
            push_o       = 1'b1;
            job_o.dest_x = cur_x_q;
            job_o.dest_y = cur_y_q;
            job_o.color  = color_q;
            job_o.pal    = pal_q;
            if (!lead_v_q) begin
              job_o.kind  = tgb_pkg::JobAscii;
              job_o.glyph = (b < tgb_pkg::ByteSpace) ? 12'd0
                                                     : 12'(b - tgb_pkg::ByteSpace);
              cur_x_d     = cur_x_q + tgb_pkg::AsciiAdv;
            end else begin
              cur_x_d = cur_x_q + tgb_pkg::HanAdv;
              if (lead_q == tgb_pkg::JamoLead && b >= tgb_pkg::JamoTrailLo &&
                  b <= tgb_pkg::JamoTrailHi) begin
                job_o.kind  = tgb_pkg::JobHangul;
                job_o.glyph = 12'(b - tgb_pkg::JamoTrailLo);
              end else if (lead_q >= tgb_pkg::SyllLeadLo && lead_q <= tgb_pkg::SyllLeadHi &&
                           b >= tgb_pkg::TrailLo && b <= tgb_pkg::TrailHi) begin
                job_o.kind  = tgb_pkg::JobHangul;
                job_o.glyph = 12'(5'(lead_q - tgb_pkg::SyllLeadLo)) * tgb_pkg::SyllPerRow
                            + 12'(b - tgb_pkg::TrailLo) + tgb_pkg::JamoCount;
              end else begin
                job_o.kind = tgb_pkg::JobBlank;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      esc_q    <= 1'b0;
      lead_v_q <= 1'b0;
      lead_q   <= '0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      color_q  <= '0;
      slots_q  <= '0;
      pal_q    <= tgb_pkg::NoIndex;
    end else begin
      active_q <= active_d;
      esc_q    <= esc_d;
      lead_v_q <= lead_v_d;
      lead_q   <= lead_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      color_q  <= color_d;
      slots_q  <= slots_d;
      pal_q    <= pal_d;
    end
  end

endmodule

@@ rtl/tgb_fifo.sv @@
// ----------------------------------------------------------------------------
// tgb_fifo
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tgb_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tgb_pkg::job_t       job_i,
  input  logic                pop_i,
  output tgb_pkg::job_t       job_o,
  output tgb_pkg::q_status_t  status_o
);

  tgb_pkg::job_t  mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  assign job_o          = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

@@ rtl/tgb_back.sv @@
// ----------------------------------------------------------------------------
// tgb_back
// Turns jobs into atlas rectangles: divide the glyph number by the row
// pitch, scale to cell edges, and hold the result in the output register.
// ----------------------------------------------------------------------------
module tgb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tgb_pkg::job_t       job_i,
  input  tgb_pkg::q_status_t  status_i,
  output logic                pop_o,
  tgb_out_if.source           out_o
);

  logic               s1_valid_q;
  tgb_pkg::job_t      s1_job_q;
  logic [5:0]         s1_quo_q;
  logic               out_valid_q;
  tgb_pkg::out_item_t out_q, out_d;

  logic               adv, s1_load;
  logic [25:0]        prod;
  logic [6:0]         rem;
  logic [9:0]         hx1, ax1;
  logic [8:0]         hy1;

  assign adv     = !out_valid_q || out_o.ready;
  assign s1_load = !s1_valid_q || adv;
  assign pop_o   = s1_load && !status_i.empty;

  // reciprocal multiply for the row number
  assign prod = {14'b0, job_i.glyph} * {12'b0, tgb_pkg::HanRecip};

  assign rem = 7'(s1_job_q.glyph - 12'(s1_quo_q) * tgb_pkg::HanPitch);
  assign hx1 = 10'(rem) * tgb_pkg::HanW;
  assign hy1 = 9'(s1_quo_q) * tgb_pkg::HanH + tgb_pkg::HanTop;
  assign ax1 = 10'(s1_job_q.glyph[6:0]) * tgb_pkg::AsciiW + tgb_pkg::AsciiLeft;

  always_comb begin
    out_d = '0;
    if (s1_job_q.kind != tgb_pkg::JobTerm) begin
      out_d.available     = 1'b1;
      out_d.dest_x        = s1_job_q.dest_x;
      out_d.dest_y        = s1_job_q.dest_y;
      out_d.draw_color    = s1_job_q.color;
      out_d.palette_index = s1_job_q.pal;
    end
    case (s1_job_q.kind)
      tgb_pkg::JobAscii: begin
        out_d.src_x1 = ax1;
        out_d.src_y1 = tgb_pkg::AsciiTop;
        out_d.src_x2 = ax1 + tgb_pkg::AsciiW;
        out_d.src_y2 = tgb_pkg::AsciiTop + tgb_pkg::AsciiH;
      end
      tgb_pkg::JobHangul: begin
        out_d.src_x1 = hx1;
        out_d.src_y1 = hy1;
        out_d.src_x2 = hx1 + tgb_pkg::HanW;
        out_d.src_y2 = hy1 + tgb_pkg::HanH;
      end
      tgb_pkg::JobBlank: begin
        // blank cell: fixed edges in field order
        out_d.src_x1 = '0;
        out_d.src_y1 = tgb_pkg::AsciiTop;
        out_d.src_x2 = tgb_pkg::HanW;
        out_d.src_y2 = tgb_pkg::HanH;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) s1_valid_q <= !status_i.empty;
      if (adv)     out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_job_q <= job_i;
      s1_quo_q <= prod[tgb_pkg::HanShift +: 6];
    end
    if (adv && s1_valid_q) out_q <= out_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

@@ rtl/text_to_glyph_blit_rects.sv @@
// ----------------------------------------------------------------------------
// text_to_glyph_blit_rects
// Maps a NUL-ended ASCII / KS X 1001 string to font atlas blit rectangles.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      beat
//   in_i     in   valid/ready    begin command or one text byte
//   out_o    out  valid/ready    one blit rectangle or terminator record
//
// One input beat per cycle is taken as long as the two-entry job queue has
// room; a result passes through the queue write, the division stage register
// and the output register, in that order, before it is presented. The row
// division by 85 is a reciprocal multiply in the first back-end stage, so it
// needs no register of its own.
// Reset clears the string state, queue and pipeline valids; palette index
// returns to none. A stall on out_o holds the output register and back-end
// stage, fills the queue, and then drops in_i.ready.
//
module text_to_glyph_blit_rects #(
  parameter int MAX_RECTS = 4095
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgb_in_if.sink     in_i,
  tgb_out_if.source  out_o
);

  logic                push, pop;
  tgb_pkg::job_t       push_job, head_job;
  tgb_pkg::q_status_t  q_status;

  // Front end: string state machine and glyph classification
  tgb_front #(
    .MAX_RECTS (MAX_RECTS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .status_i (q_status),
    .push_o   (push),
    .job_o    (push_job)
  );

  // Queue decouples byte intake from rectangle delivery
  tgb_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (head_job),
    .status_o (q_status)
  );

  // Back end: atlas coordinates and output register
  tgb_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (head_job),
    .status_i (q_status),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  // Never write a full queue or read an empty one
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full) else $error("job pushed into full queue");

  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty) else $error("job popped from empty queue");

  // Terminator records carry no coordinates or color
  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.payload.available |->
      out_o.payload.dest_x == 16'sd0 && out_o.payload.src_x1 == 10'd0 &&
      out_o.payload.src_y2 == 9'd0 && out_o.payload.draw_color == 32'd0)
    else $error("terminator record with nonzero fields");

  // A real cell is 6 or 12 wide
  a_cell_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.available && out_o.payload.src_x1 != 10'd0 |->
      out_o.payload.src_x2 == out_o.payload.src_x1 + 10'd6 ||
      out_o.payload.src_x2 == out_o.payload.src_x1 + 10'd12)
    else $error("glyph cell with wrong width");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_to_glyph_blit_rects. A short table of
// hand-picked beats covers the corner cases. Random strings follow: ASCII,
// palette escapes, KS X 1001 pairs, broken pairs and open-ended strings.
// Every accepted input beat runs through a behavioral predictor. Each output
// beat is checked field by field against the oldest predicted rectangle.
// ----------------------------------------------------------------------------
module tb;

  localparam int MaxRects = 4095;

  // Atlas layout, kept apart from the design's own constants
  localparam logic [9:0]  AscCellW   = 10'd6;
  localparam logic [9:0]  AscCellX0  = 10'd6;
  localparam logic [8:0]  AscRow     = 9'd20;
  localparam logic [8:0]  CellH      = 9'd12;
  localparam logic [9:0]  HanCellW   = 10'd12;
  localparam logic [8:0]  HanRow0    = 9'd32;
  localparam logic [11:0] HanPerRow  = 12'd85;
  localparam logic [11:0] SyllRowLen = 12'd94;
  localparam logic [11:0] JamoTotal  = 12'd51;
  localparam logic [15:0] AscStep    = 16'd6;
  localparam logic [15:0] HanStep    = 16'd12;

  // Stop feeding random strings once this many live beats went in
  localparam int TextBeats = 1900;
  // Receiver holds off once, for this long, after this many rectangles
  localparam int HoldOffAfter  = 150;
  localparam int HoldOffCycles = 400;

  typedef struct {
    tgb_pkg::in_item_t  beat;
    bit                 typed;
    tgb_pkg::out_item_t rect;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tgb_in_if  in_if ();
  tgb_out_if out_if ();

  text_to_glyph_blit_rects #(
    .MAX_RECTS (MaxRects)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predicted string state
  // --------------------------------------------------------------------------
  bit          str_open   = 1'b0;
  bit          esc_wait   = 1'b0;
  bit          lead_wait  = 1'b0;
  logic [7:0]  lead_hold  = '0;
  logic [15:0] pen_x      = '0;
  logic [15:0] pen_y      = '0;
  logic [31:0] ink        = '0;
  logic [12:0] slots      = '0;
  logic [5:0]  pal_sel    = tgb_pkg::NoIndex;

  tgb_pkg::out_item_t rect_q[$];       // rectangles still owed by the block
  dir_row_t           dir_rows[$];
  int                 n_mismatch = 0;
  int                 live_beats = 0;
  int                 rects_seen = 0;
  bit                 burst      = 1'b0;

  function automatic tgb_pkg::out_item_t glyph_rect(logic [15:0] dx, logic [15:0] dy,
                                                    logic [9:0] x1, logic [8:0] y1,
                                                    logic [9:0] x2, logic [8:0] y2,
                                                    logic [31:0] color, logic [5:0] pal);
    tgb_pkg::out_item_t r;
    r.available     = 1'b1;
    r.dest_x        = dx;
    r.dest_y        = dy;
    r.src_x1        = x1;
    r.src_y1        = y1;
    r.src_x2        = x2;
    r.src_y2        = y2;
    r.draw_color    = color;
    r.palette_index = pal;
    return r;
  endfunction

  // Advance the predicted state by one accepted beat; flag a rectangle.
  task automatic predict_beat(input tgb_pkg::in_item_t it, output bit hit,
                              output tgb_pkg::out_item_t rect);
    logic [7:0]  b;
    logic [15:0] code;
    logic [11:0] g;
    logic [9:0]  c;
    logic [9:0]  x1;
    logic [8:0]  y1;
    bit          pair;
    hit  = 1'b0;
    rect = '0;
    b    = it.text_byte;
    if (it.cmd == tgb_pkg::CmdBegin) begin
      str_open  = 1'b1;
      esc_wait  = 1'b0;
      lead_wait = 1'b0;
      lead_hold = '0;
      pen_x     = it.start_x;
      pen_y     = it.start_y;
      ink       = it.default_color;
      slots     = (it.rect_capacity > MaxRects) ? 13'(MaxRects) : 13'(it.rect_capacity);
    end else if (!str_open) begin
      // drop: no string open
    end else if (b == tgb_pkg::ByteNul) begin
      // terminator; any pending lead or escape is dropped
      esc_wait  = 1'b0;
      lead_wait = 1'b0;
      str_open  = 1'b0;
      hit       = 1'b1;
    end else if (esc_wait) begin
      esc_wait = 1'b0;
      if (b == tgb_pkg::ByteAt) begin
        pal_sel = tgb_pkg::NoIndex;
      end else if (b >= tgb_pkg::ByteDigit0 && b <= tgb_pkg::ByteDigit9) begin
        pal_sel = 6'(b - tgb_pkg::ByteDigit0);
      end else if (b >= tgb_pkg::ByteUpperA && b <= tgb_pkg::ByteUpperZ) begin
        pal_sel = 6'(b - tgb_pkg::ByteUpperA + 8'd10);
      end else if (b >= tgb_pkg::ByteLowerA && b <= tgb_pkg::ByteLowerZ) begin
        pal_sel = 6'(b - tgb_pkg::ByteLowerA + 8'd10);
      end
    end else if (!lead_wait && b == tgb_pkg::ByteAt) begin
      esc_wait = 1'b1;
    end else if (!lead_wait && b[7]) begin
      lead_wait = 1'b1;
      lead_hold = b;
    end else begin
      pair      = lead_wait;
      lead_wait = 1'b0;
      if (slots == 0) begin
        // out of slots: the string ends silently
        str_open = 1'b0;
      end else begin
        slots = slots - 13'd1;
        hit   = 1'b1;
        if (!pair) begin
          c    = (b < tgb_pkg::ByteSpace) ? 10'd0 : 10'(b - tgb_pkg::ByteSpace);
          x1   = c * AscCellW + AscCellX0;
          rect = glyph_rect(pen_x, pen_y, x1, AscRow, x1 + AscCellW, AscRow + CellH,
                            ink, pal_sel);
          pen_x = pen_x + AscStep;
        end else begin
          code = {lead_hold, b};
          if (code >= {tgb_pkg::JamoLead, tgb_pkg::JamoTrailLo} &&
              code <= {tgb_pkg::JamoLead, tgb_pkg::JamoTrailHi}) begin
            g = 12'(code - {tgb_pkg::JamoLead, tgb_pkg::JamoTrailLo});
          end else if (code >= {tgb_pkg::SyllLeadLo, tgb_pkg::TrailLo} &&
                       code <= {tgb_pkg::SyllLeadHi, tgb_pkg::TrailHi} &&
                       b >= tgb_pkg::TrailLo && b <= tgb_pkg::TrailHi) begin
            g = 12'((lead_hold - tgb_pkg::SyllLeadLo) * SyllRowLen +
                    (b - tgb_pkg::TrailLo) + JamoTotal);
          end else begin
            g = 12'hFFF;
          end
          if (g != 12'hFFF) begin
            x1   = 10'((g % HanPerRow) * HanCellW);
            y1   = 9'((g / HanPerRow) * CellH + HanRow0);
            rect = glyph_rect(pen_x, pen_y, x1, y1, x1 + HanCellW, y1 + CellH, ink, pal_sel);
          end else begin
            // blank cell, coordinates as the atlas record lays them out
            rect = glyph_rect(pen_x, pen_y, 10'd0, AscRow, HanCellW, CellH, ink, pal_sel);
          end
          pen_x = pen_x + HanStep;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    n_mismatch++;
    $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %0h want %0h", name, got, want));
  endtask

  task automatic check_rect(input tgb_pkg::out_item_t got);
    tgb_pkg::out_item_t want;
    if (rect_q.size() == 0) begin
      report_mismatch($sformatf("rectangle with none pending: %h", got));
      return;
    end
    want = rect_q.pop_front();
    check_field("available", got.available, want.available);
    check_field("dest_x", got.dest_x, want.dest_x);
    check_field("dest_y", got.dest_y, want.dest_y);
    check_field("src_x1", got.src_x1, want.src_x1);
    check_field("src_y1", got.src_y1, want.src_y1);
    check_field("src_x2", got.src_x2, want.src_x2);
    check_field("src_y2", got.src_y2, want.src_y2);
    check_field("draw_color", got.draw_color, want.draw_color);
    check_field("palette_index", got.palette_index, want.palette_index);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Fields unused by a beat carry random bits so every input bit toggles.
  function automatic tgb_pkg::in_item_t byte_beat(logic [7:0] b);
    tgb_pkg::in_item_t it;
    it.cmd           = tgb_pkg::CmdByte;
    it.text_byte     = b;
    it.start_x       = 16'($urandom);
    it.start_y       = 16'($urandom);
    it.default_color = $urandom;
    it.rect_capacity = 12'($urandom);
    return it;
  endfunction

  function automatic tgb_pkg::in_item_t begin_beat(logic [15:0] x, logic [15:0] y,
                                                   logic [31:0] color, logic [11:0] cap);
    tgb_pkg::in_item_t it;
    it.cmd           = tgb_pkg::CmdBegin;
    it.text_byte     = 8'($urandom);
    it.start_x       = x;
    it.start_y       = y;
    it.default_color = color;
    it.rect_capacity = cap;
    return it;
  endfunction

  function automatic void add_row(tgb_pkg::in_item_t beat, bit typed,
                                  tgb_pkg::out_item_t rect);
    dir_row_t row;
    row.beat  = beat;
    row.typed = typed;
    row.rect  = rect;
    dir_rows.push_back(row);
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one beat, hold it until taken, then predict what it causes.
  // A typed row supplies its own expected rectangle.
  task automatic send_beat(input tgb_pkg::in_item_t it, input bit typed,
                           input tgb_pkg::out_item_t want);
    int                 gap;
    bit                 hit;
    tgb_pkg::out_item_t rect;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    if (it.cmd == tgb_pkg::CmdBegin || str_open) live_beats++;
    predict_beat(it, hit, rect);
    if (typed) rect_q.push_back(want);
    else if (hit) rect_q.push_back(rect);
  endtask

  task automatic send_text(input logic [7:0] b);
    send_beat(byte_beat(b), 1'b0, '0);
  endtask

  // One random string: mostly well-formed pieces, now and then noise ahead
  // of it, a dangling lead or escape before the NUL, or no end at all.
  task automatic send_string();
    int          len;
    int          kind;
    int          r;
    logic [11:0] cap;
    burst = ($urandom_range(0, 3) == 0);
    if (!str_open && $urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 3)) send_text(8'($urandom));
    end
    r = $urandom_range(0, 99);
    if (r < 70)      cap = 12'($urandom_range(0, 24));
    else if (r < 90) cap = 12'($urandom_range(25, 200));
    else if (r < 98) cap = 12'($urandom);
    else             cap = 12'hFFF;
    send_beat(begin_beat(16'($urandom), 16'($urandom), $urandom, cap), 1'b0, '0);
    len = $urandom_range(0, 30);
    repeat (len) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_text(8'($urandom_range(tgb_pkg::ByteSpace, 8'h7F)));
      end else if (kind < 48) begin
        send_text(8'($urandom_range(1, 8'h1F)));
      end else if (kind < 58) begin
        send_text(tgb_pkg::ByteAt);
        case ($urandom_range(0, 4))
          0: send_text(8'($urandom_range(tgb_pkg::ByteDigit0, tgb_pkg::ByteDigit9)));
          1: send_text(8'($urandom_range(tgb_pkg::ByteUpperA, tgb_pkg::ByteUpperZ)));
          2: send_text(8'($urandom_range(tgb_pkg::ByteLowerA, tgb_pkg::ByteLowerZ)));
          3: send_text(tgb_pkg::ByteAt);
          default: send_text(8'($urandom_range(1, 255)));
        endcase
      end else if (kind < 73) begin
        send_text(tgb_pkg::JamoLead);
        send_text(8'($urandom_range(tgb_pkg::JamoTrailLo, tgb_pkg::JamoTrailHi)));
      end else if (kind < 93) begin
        send_text(8'($urandom_range(tgb_pkg::SyllLeadLo, tgb_pkg::SyllLeadHi)));
        send_text(8'($urandom_range(tgb_pkg::TrailLo, tgb_pkg::TrailHi)));
      end else begin
        // any lead with any trail, '@' and 7-bit trails included
        send_text(8'($urandom_range(8'h80, 8'hFF)));
        send_text(8'($urandom_range(1, 255)));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 80) begin
      send_text(tgb_pkg::ByteNul);
    end else if (r < 90) begin
      send_text((r < 85) ? tgb_pkg::ByteAt : 8'($urandom_range(8'h80, 8'hFF)));
      send_text(tgb_pkg::ByteNul);
    end
    // otherwise leave it open; the next begin abandons it
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int spins;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Typed rows carry a rectangle read straight off the
    // atlas layout; the rest go through the predictor.
    add_row(byte_beat(tgb_pkg::ByteUpperA), 1'b0, '0);  // no string open: drop
    add_row(begin_beat(16'h7FFF, 16'h8000, 32'hFFFF_FFFF, 12'hFFF), 1'b0, '0);
    add_row(byte_beat(tgb_pkg::ByteSpace), 1'b1,
            glyph_rect(16'h7FFF, 16'h8000, 10'd6, 9'd20, 10'd12, 9'd32,
                       32'hFFFF_FFFF, tgb_pkg::NoIndex));
    // last ASCII cell, and x wraps past the positive limit
    add_row(byte_beat(8'h7F), 1'b1,
            glyph_rect(16'h8005, 16'h8000, 10'd576, 9'd20, 10'd582, 9'd32,
                       32'hFFFF_FFFF, tgb_pkg::NoIndex));
    add_row(byte_beat(8'h1F), 1'b0, '0);      // control byte drawn as space
    add_row(byte_beat(tgb_pkg::ByteAt), 1'b0, '0);
    add_row(byte_beat(tgb_pkg::ByteUpperZ), 1'b0, '0); // index 35
    add_row(byte_beat(tgb_pkg::ByteLowerA), 1'b0, '0);
    add_row(byte_beat(tgb_pkg::ByteAt), 1'b0, '0);
    add_row(byte_beat(tgb_pkg::ByteDigit9), 1'b0, '0);
    add_row(byte_beat(tgb_pkg::JamoLead), 1'b0, '0);   // first jamo
    add_row(byte_beat(tgb_pkg::JamoTrailLo), 1'b0, '0);
    add_row(byte_beat(tgb_pkg::SyllLeadHi), 1'b0, '0); // last syllable
    add_row(byte_beat(tgb_pkg::TrailHi), 1'b0, '0);
    add_row(byte_beat(8'hFF), 1'b0, '0);      // '@' taken as trail: blank cell
    add_row(byte_beat(tgb_pkg::ByteAt), 1'b0, '0);
    add_row(byte_beat(tgb_pkg::ByteAt), 1'b0, '0);     // "@@" clears the index
    add_row(byte_beat(tgb_pkg::ByteAt), 1'b0, '0);
    add_row(byte_beat(tgb_pkg::SyllLeadLo), 1'b0, '0);
    add_row(byte_beat(tgb_pkg::ByteNul), 1'b1, '0);    // NUL after a lead: terminator
    add_row(begin_beat(16'h0000, 16'h0000, 32'h0000_0000, 12'd1), 1'b0, '0);
    add_row(byte_beat(tgb_pkg::ByteAt), 1'b0, '0);
    add_row(byte_beat(8'h21), 1'b0, '0);      // other byte after '@': swallow
    add_row(byte_beat(8'h51), 1'b0, '0);      // takes the only slot
    add_row(byte_beat(8'h52), 1'b0, '0);      // no slot left: string ends
    add_row(begin_beat(16'hFFFF, 16'h7FFF, 32'h5A5A_A5A5, 12'd5), 1'b0, '0);
    add_row(byte_beat(8'h53), 1'b0, '0);
    add_row(begin_beat(16'h8000, 16'h0001, 32'h0000_0001, 12'd0), 1'b0, '0);
    add_row(byte_beat(tgb_pkg::ByteNul), 1'b1, '0);    // terminator needs no slot

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].rect);

    while (live_beats < TextBeats) send_string();
    in_if.valid <= 1'b0;

    // Drain, then idle a little longer so a stray rectangle would show up.
    spins = 0;
    while (rect_q.size() != 0 && spins < 50000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (20) @(posedge clk_i);
    if (rect_q.size() != 0) begin
      report_mismatch($sformatf("%0d rectangles never arrived", rect_q.size()));
    end

    if (n_mismatch == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, quiet stretches, and one long hold-off that
  // backs the block up until it drops in_i.ready.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int  hold;
    int  calm;
    int  r;
    bit  held_off;
    hold         = 0;
    calm         = 0;
    held_off     = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        check_rect(out_if.payload);
        rects_seen++;
      end
      if (!held_off && rects_seen >= HoldOffAfter) begin
        held_off = 1'b1;
        hold     = HoldOffCycles;
        calm     = 0;
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else if (calm > 0) begin
        out_if.ready <= 1'b1;
        calm--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_if.ready <= 1'b1;
        end else if (r < 73) begin
          out_if.ready <= 1'b1;
          calm = $urandom_range(30, 80);
        end else begin
          out_if.ready <= 1'b0;
          if (r < 95)      hold = $urandom_range(0, 3);
          else if (r < 99) hold = $urandom_range(4, 12);
          else             hold = $urandom_range(20, 60);
        end
      end
    end
  end

  // Give up if the run hangs; far beyond the slowest correct run.
  initial begin : watchdog
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tgb_pkg.sv
rtl/tgb_in_if.sv
rtl/tgb_out_if.sv
rtl/tgb_front.sv
rtl/tgb_fifo.sv
rtl/tgb_back.sv
rtl/text_to_glyph_blit_rects.sv
sim/tb.sv
